// ===== src/substring_replace_stream_defines.svh =====
// assertion helpers for the find and replace block
`ifndef SUBSTRING_REPLACE_STREAM_DEFINES_SVH
`define SUBSTRING_REPLACE_STREAM_DEFINES_SVH

// condition and consequence in the same cycle
`define SRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/srs_pkg.sv =====
`default_nettype none

package srs_pkg;

	localparam int LEN_W      = 4;
	localparam int DATA_W     = 64;
	localparam int IDX_W      = 2;
	localparam int CMD_LANES  = 8;
	localparam int BEAT_W     = $clog2(CMD_LANES);
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [IDX_W-1:0] REG_PATTERN_BYTES     = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_PATTERN_LEN       = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_REPLACEMENT_BYTES = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_REPLACEMENT_LEN   = IDX_W'(3);

	// one accepted byte turned into a run of output bytes
	typedef struct packed {
		logic [CMD_LANES-1:0][7:0] lanes;
		logic [LEN_W-1:0]          count;
		logic                      last;
	} cmd_t;

endpackage

`default_nettype wire

// ===== src/srs_front.sv =====
`default_nettype none

module srs_front #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [srs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [srs_pkg::DATA_W-1:0]   cfg_data,
	input  logic                         accept,
	input  logic [7:0]                   in_byte,
	input  logic                         in_last,
	output logic                         cmd_push,
	output srs_pkg::cmd_t                cmd
);
	import srs_pkg::*;

	localparam int FW = $clog2(MAX_PATTERN + 1);

	logic [DATA_W-1:0] pat_q, repl_q;
	logic [LEN_W-1:0]  plen_q, rlen_q;
	logic [FW-1:0]     fill_q;
	logic [7:0]        win_q [MAX_PATTERN];

	logic [LEN_W-1:0]  plen, rlen, fill_ext, f_new;
	logic              stale, at_len, hit, shift;
	logic [7:0]        w_ins [MAX_PATTERN];
	logic [7:0]        w_nxt [MAX_PATTERN];
	logic [FW-1:0]     fill_nxt;
	cmd_t              cmd_c;

	always_comb begin
		plen = (plen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_q;
		rlen = (rlen_q > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rlen_q;
		fill_ext = LEN_W'(fill_q);
		f_new = fill_ext + LEN_W'(1);
		// window holds at least a full pattern: length was lowered mid text
		stale = fill_ext >= plen;
		at_len = !stale && (f_new == plen);
		hit = at_len;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			w_ins[k] = (LEN_W'(k) == fill_ext) ? in_byte : win_q[k];
			if (LEN_W'(k) < plen && w_ins[k] != pat_q[8*k +: 8])
				hit = 1'b0;
		end

		cmd_c.lanes = '0;
		cmd_c.count = '0;
		cmd_c.last = in_last;
		fill_nxt = fill_q;
		shift = 1'b0;
		if (hit) begin
			for (int k = 0; k < CMD_LANES; k++)
				if (LEN_W'(k) < rlen)
					cmd_c.lanes[k] = repl_q[8*k +: 8];
			cmd_c.count = rlen;
			fill_nxt = '0;
		end else if (stale || in_last) begin
			// new byte sits right after the held ones, so send them all
			for (int k = 0; k < MAX_PATTERN; k++)
				if (LEN_W'(k) < f_new)
					cmd_c.lanes[k] = w_ins[k];
			cmd_c.count = f_new;
			fill_nxt = '0;
		end else if (at_len) begin
			// miss: oldest byte leaves, fill stays at pattern length minus one
			cmd_c.lanes[0] = w_ins[0];
			cmd_c.count = LEN_W'(1);
			shift = 1'b1;
		end else begin
			fill_nxt = FW'(f_new);
		end

		for (int k = 0; k < MAX_PATTERN - 1; k++)
			w_nxt[k] = shift ? w_ins[k+1] : w_ins[k];
		w_nxt[MAX_PATTERN-1] = shift ? 8'd0 : w_ins[MAX_PATTERN-1];
	end

	assign cmd_push = accept && (cmd_c.count != '0 || in_last);
	assign cmd = cmd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			repl_q <= '0;
			plen_q <= '0;
			rlen_q <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PATTERN_BYTES:     pat_q <= cfg_data;
					REG_PATTERN_LEN:       plen_q <= cfg_data[LEN_W-1:0];
					REG_REPLACEMENT_BYTES: repl_q <= cfg_data;
					REG_REPLACEMENT_LEN:   rlen_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (accept)
				fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			for (int k = 0; k < MAX_PATTERN; k++)
				win_q[k] <= w_nxt[k];
	end

endmodule

`default_nettype wire

// ===== src/srs_cmdq.sv =====
`default_nettype none

module srs_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  srs_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output srs_pkg::cmd_t rd_cmd,
	output logic          empty
);
	import srs_pkg::*;

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_wr, do_rd;

	assign full = cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: wr_ptr_q + CMDQ_PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
					: rd_ptr_q + CMDQ_PTR_W'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CMDQ_CNT_W'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CMDQ_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

`default_nettype wire

// ===== src/srs_back.sv =====
`default_nettype none

module srs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  srs_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          q_pop,
	output logic [7:0]    out_byte,
	output logic          out_valid,
	output logic          out_last,
	output logic          empty,
	input  logic          pop
);
	import srs_pkg::*;

	logic [BEAT_W-1:0] idx_q;
	logic              oreg_full_q;
	logic [7:0]        byte_q;
	logic              vbit_q, last_q;
	logic              load, last_beat;

	// an empty run still yields one beat: the end marker
	assign last_beat = (head.count == '0) || (LEN_W'(idx_q) == head.count - LEN_W'(1));
	assign load = !q_empty && (!oreg_full_q || pop);
	assign q_pop = load && last_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oreg_full_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load)
				oreg_full_q <= 1'b1;
			else if (pop)
				oreg_full_q <= 1'b0;
			if (load)
				idx_q <= last_beat ? '0 : idx_q + BEAT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.lanes[idx_q];
			vbit_q <= head.count != '0;
			last_q <= head.last && last_beat;
		end
	end

	assign out_byte = byte_q;
	assign out_valid = vbit_q;
	assign out_last = last_q;
	assign empty = !oreg_full_q;

endmodule

`default_nettype wire

// ===== src/substring_replace_stream.sv =====
// Streaming find and replace over a byte stream.
// Input side is a queue write: a byte and its last flag go in at an edge with push high
// and full low. Result side is a queue read: the oldest beat sits on out_byte, out_valid
// and out_last while empty is low and leaves at an edge with pop high.
// Configuration: cfg_we, cfg_index (0 pattern bytes, 1 pattern length, 2 replacement
// bytes, 3 replacement length) and cfg_data, to be written by the user only while the
// block is idle; the block itself does not enforce this. Each beat is one byte of
// rewritten text; a beat with out_valid low is the end marker of a text whose last
// byte left nothing to send, and it carries out_last. With the result side drained,
// the run for a byte passes the run queue and then the output register, which drives
// its first beat onto the outputs. Throughput: one byte in per cycle; results leave at
// one beat per cycle while pop is high, so a match holds the result port for one beat
// per replacement byte and the input stalls only once the two-entry run queue and the
// output register have filled. Reset clears the configuration to zero (pass through),
// empties the window, the run queue and the output register. When the receiver stops
// popping, the beat holds, the run queue fills and full rises; nothing is dropped.
`default_nettype none
`include "substring_replace_stream_defines.svh"

module substring_replace_stream #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [srs_pkg::IDX_W-1:0]  cfg_index,
	input  logic [srs_pkg::DATA_W-1:0] cfg_data,
	input  logic [7:0]                 in_byte,
	input  logic                       in_last,
	input  logic                       push,
	output logic                       full,
	output logic [7:0]                 out_byte,
	output logic                       out_valid,
	output logic                       out_last,
	output logic                       empty,
	input  logic                       pop
);
	import srs_pkg::*;

	logic accept, cmd_push, q_full, q_empty, q_pop;
	cmd_t cmd, head;

	assign full = q_full;
	assign accept = push && !q_full;

	srs_front #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	srs_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (head),
		.empty  (q_empty)
	);

	srs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last),
		.empty     (empty),
		.pop       (pop)
	);

	`SRS_ASSERT_NOW(a_marker_is_last, !empty && !out_valid, out_last, "end marker without last")
	`SRS_ASSERT_NEXT(a_output_refills, empty && !q_empty, !empty, "output register not refilled")
	`SRS_ASSERT_NEXT(a_push_lands, cmd_push, !q_empty, "pushed run missing from queue")

endmodule

`default_nettype wire
